/* src/kvt_pkg.sv */
package kvt_pkg;

  // Table geometry
  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int CAP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Request action codes
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_GET = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISS     = 3'd4;

endpackage

/* src/key_value_table_upsert_lookup_unit.sv */
// Operation: a request is accepted in IDLE; a linear scan reads entries 0 to count-1 in order
//   through the single read port of the key and value memories and stops at the first match;
//   an empty table skips the scan. The result is registered once the result register is free.
//   A new request is taken only after the current one has finished.
// Reset: rst (synchronous, active high) empties the table and sets capacity to 64; the
//   memories themselves are not cleared, entries beyond the fill count are never compared.
module key_value_table_upsert_lookup_unit
  import kvt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // capacity register write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_data,
  // request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic signed [KEY_W-1:0]  key,
  input  logic signed [VAL_W-1:0]  value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic signed [VAL_W-1:0]  read_value
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  localparam int EXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Storage: dense table filled from entry 0, one synchronous read port each
  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  logic [CAP_W-1:0] capacity;

  // Latched request
  logic             req_action;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_value;

  // Scan pipeline: issue stage and compare stage
  logic [CNT_W-1:0] issue_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;

  // Scan outcome
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic [VAL_W-1:0] found_val;

  logic             issuing;
  logic             match;
  logic [IDX_W-1:0] rd_addr;
  logic [EXT_W-1:0] cap_ext;
  logic [CNT_W-1:0] cap_eff;
  logic             out_free;
  logic             finish_go;
  logic             room;

  // Memory write port controls
  logic             key_we;
  logic             val_we;
  logic [IDX_W-1:0] wr_addr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign issuing = (state == S_SCAN) && (issue_idx < count);
  assign rd_addr = issue_idx[IDX_W-1:0];
  assign match   = cmp_valid && (key_rd == req_key);

  // Effective capacity saturates at the table depth
  always_comb begin
    cap_ext = EXT_W'(capacity);
    if (cap_ext > EXT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cap_ext[CNT_W-1:0];
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign finish_go = (state == S_FINISH) && out_free;
  assign room      = (count < cap_eff);

  // Write-back decision, taken only in the finishing cycle
  always_comb begin
    key_we  = 1'b0;
    val_we  = 1'b0;
    wr_addr = count[IDX_W-1:0];
    if (finish_go && (req_action == ACT_ADD)) begin
      if (found) begin
        val_we  = 1'b1;
        wr_addr = found_idx;
      end else if (room) begin
        key_we = 1'b1;
        val_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= req_key;
    end
    if (val_we) begin
      val_mem[wr_addr] <= req_value;
    end
    key_rd <= key_mem[rd_addr];
    val_rd <= val_mem[rd_addr];
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Control: accept, scan, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      issue_idx <= '0;
      found     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            issue_idx <= '0;
            cmp_valid <= 1'b0;
            found     <= 1'b0;
            state     <= (count == '0) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (match) begin
            // first match wins; keys are unique so this is the only one
            found     <= 1'b1;
            cmp_valid <= 1'b0;
            state     <= S_FINISH;
          end else begin
            cmp_valid <= issuing;
            if (!issuing && !cmp_valid) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            if ((req_action == ACT_ADD) && !found && room) begin
              count <= count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request and scan payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_action <= action;
      req_key    <= key;
      req_value  <= value;
    end
    cmp_idx <= rd_addr;
    if ((state == S_SCAN) && match) begin
      found_idx <= cmp_idx;
      found_val <= val_rd;
    end
  end

  // Result register: holds a finished result while the next request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      read_value <= '0;
      if (req_action == ACT_ADD) begin
        if (found) begin
          status <= ST_UPDATED;
        end else if (room) begin
          status <= ST_INSERTED;
        end else begin
          status <= ST_FULL;
        end
      end else if (found) begin
        status     <= ST_HIT;
        read_value <= found_val;
      end else begin
        status <= ST_MISS;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in progress");

  a_count_on_insert: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |-> (out_valid && (status == ST_INSERTED)))
    else $error("fill count moved without an insert result");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_HIT) |-> (read_value == '0))
    else $error("read value not zero outside a hit");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import kvt_pkg::*;

  // Request as queued for the driver
  typedef struct packed {
    logic             act;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } kv_request_t;

  // Result as predicted
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
  } kv_result_t;

  localparam int POOL_N      = 80;  // more keys than entries, so the table can fill
  localparam int LONG_HOLD   = 400; // receiver hold-off, in cycles
  localparam int TAIL_CYCLES = 80;  // a little over one full-table scan

  logic              clk;
  logic              rst        = 1'b1;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic              action     = ACT_ADD;
  logic [KEY_W-1:0]  key        = '0;
  logic [VAL_W-1:0]  value      = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  read_value;

  key_value_table_upsert_lookup_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_value (read_value)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow of the table: keys, values, fill count, capacity register
  logic [KEY_W-1:0] table_keys [DEPTH];
  logic [VAL_W-1:0] table_vals [DEPTH];
  int               table_fill     = 0;
  logic [CAP_W-1:0] table_capacity = CAP_RESET;

  kv_request_t      pending_requests[$];
  kv_result_t       expected_results[$];
  logic [KEY_W-1:0] key_pool [POOL_N];

  int  requests_queued = 0;
  int  results_checked = 0;
  int  errors          = 0;
  int  cap_writes      = 0;
  int  status_seen [5] = '{default: 0};
  bit  idle_on         = 1'b1;  // random idling on both sides
  int  hold_asked      = 0;     // bumped to ask the receiver for a long hold-off
  int  hold_done       = 0;
  int  send_gap        = 0;
  int  recv_gap        = 0;
  int  recv_hold       = 0;
  kv_request_t next_req;
  kv_result_t  want;

  // Works out the result of one accepted request and updates the shadow table.
  // Scan stops at the first match; capacity saturates at DEPTH; entries above a
  // lowered capacity stay reachable.
  function automatic void predict_request(input logic act, input logic [KEY_W-1:0] k,
                                          input logic [VAL_W-1:0] v);
    int         slot;
    int         lim;
    kv_result_t r;
    slot = -1;
    for (int i = 0; i < table_fill; i++)
      if (slot < 0 && table_keys[i] == k) slot = i;
    lim = (int'(table_capacity) > DEPTH) ? DEPTH : int'(table_capacity);
    r.read_value = '0;
    if (act == ACT_ADD) begin
      if (slot >= 0) begin
        table_vals[slot] = v;
        r.status = ST_UPDATED;
      end else if (table_fill < lim) begin
        table_keys[table_fill] = k;
        table_vals[table_fill] = v;
        table_fill++;
        r.status = ST_INSERTED;
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      if (slot >= 0) begin
        r.read_value = table_vals[slot];
        r.status = ST_HIT;
      end else begin
        r.status = ST_MISS;
      end
    end
    status_seen[r.status]++;
    expected_results.push_back(r);
  endfunction

  function automatic void queue_request(input logic act, input logic [KEY_W-1:0] k,
                                        input logic [VAL_W-1:0] v);
    kv_request_t q;
    q.act   = act;
    q.key   = k;
    q.value = v;
    pending_requests.push_back(q);
    requests_queued++;
  endfunction

  // Mostly keys from the pool so that updates and hits are common; the rest
  // fully random, which also toggles every key bit.
  function automatic void queue_random(input int n);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) k = $urandom();
      else k = key_pool[$urandom_range(0, POOL_N - 1)];
      queue_request(logic'($urandom_range(0, 1)), k, $urandom());
    end
  endfunction

  // Waits until every queued request has produced its result.
  task automatic drain();
    while (results_checked != requests_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Capacity write; only called with the block idle, in step with the clock.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_data  <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    table_capacity = cap;
    cap_writes++;
  endtask

  // Driver: offers the next pending request once the current one is taken,
  // with random bursts of idle cycles in between.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_request(action, key, value);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          action   <= next_req.act;
          key      <= next_req.key;
          value    <= next_req.value;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // drives out_ready, including the long hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d read_value %h",
                 status, read_value);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, read_value);
            errors++;
          end
          results_checked++;
        end
      end
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        recv_hold = LONG_HOLD;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and sequencing
  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Capacity zero: lookup on an empty table, new key dropped
    write_capacity(CAP_W'(0));
    queue_request(ACT_GET, 32'h0000_0000, 32'h1234_5678);
    queue_request(ACT_ADD, 32'h7fff_ffff, 32'hffff_ffff);
    queue_request(ACT_GET, 32'h7fff_ffff, 32'h0000_0000);
    drain();

    // Room for one: insert, update in place, hit, then full, a miss and full again
    write_capacity(CAP_W'(1));
    queue_request(ACT_ADD, 32'h8000_0000, 32'h7fff_ffff);
    queue_request(ACT_ADD, 32'h8000_0000, 32'h8000_0000);
    queue_request(ACT_GET, 32'h8000_0000, 32'hffff_ffff);
    queue_request(ACT_ADD, 32'h7fff_ffff, 32'h0000_0001);
    queue_request(ACT_GET, 32'hffff_ffff, 32'h0000_0000);
    queue_request(ACT_ADD, 32'h0000_0000, 32'h0000_0000);
    drain();

    // Largest register value, saturating at DEPTH
    write_capacity(CAP_W'(127));
    queue_request(ACT_ADD, 32'h7fff_ffff, 32'hffff_ffff);
    queue_request(ACT_ADD, 32'h0000_0000, 32'h0000_0000);
    queue_request(ACT_ADD, 32'hffff_ffff, 32'h8000_0000);
    queue_request(ACT_GET, 32'h7fff_ffff, 32'h0000_0000);
    queue_request(ACT_GET, 32'h0000_0000, 32'hffff_ffff);
    queue_request(ACT_GET, 32'hffff_ffff, 32'h0000_0000);
    queue_request(ACT_GET, 32'h8000_0000, 32'h0000_0000);
    queue_request(ACT_GET, 32'h0000_3039, 32'h0000_0000);
    drain();

    // Capacity below the fill count: old entries stay live, new keys dropped
    write_capacity(CAP_W'(2));
    queue_request(ACT_ADD, 32'h5555_5555, 32'haaaa_aaaa);
    queue_request(ACT_ADD, 32'h0000_0000, 32'h5555_5555);
    queue_request(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    queue_request(ACT_GET, 32'haaaa_aaaa, 32'h0000_0000);
    drain();

    // Random phases. The first one asks for a long receiver hold-off while the
    // sender keeps offering, so the block backs up and drops in_ready.
    write_capacity(CAP_W'(20));
    queue_random(150);
    hold_asked++;
    drain();

    write_capacity(CAP_W'(0));
    queue_random(100);
    drain();

    // Table fills to DEPTH here; the sender also pauses halfway for a full drain
    write_capacity(CAP_W'(127));
    queue_random(100);
    drain();
    queue_random(100);
    drain();

    write_capacity(CAP_W'(64));
    queue_random(150);
    drain();

    write_capacity(CAP_W'(7));
    queue_random(100);
    drain();

    // Closing stretch at full rate, no idling on either side
    write_capacity(CAP_W'(64));
    idle_on = 1'b0;
    queue_random(100);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      errors++;
    end

    $display("Covered %0d requests over %0d capacity writes (0, 1, 2, 7, 20, 64, 127).",
             requests_queued, cap_writes);
    $display("Results: %0d inserted, %0d updated, %0d full, %0d hits, %0d misses.",
             status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_FULL],
             status_seen[ST_HIT], status_seen[ST_MISS]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run
  initial begin
    #8_000_000;
    $display("timeout: %0d of %0d results checked", results_checked, requests_queued);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
